### sv/fwna_pkg.sv
// ----------------------------------------------------------------------------
// fwna_pkg: shared types and constants for fixed-width number to ASCII
// Item payloads, controller/datapath link structs, mode codes, character
// constants and the digit to character mapping.
// ----------------------------------------------------------------------------
package fwna_pkg;

  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 6;
  localparam int STEP_W     = 5;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int BCD_W      = 4 * DEC_DIGITS;

  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_BIN  = 2'd3;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  typedef struct packed {
    logic [1:0]         operation;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
    logic [2:0]         text_line;
    logic [4:0]         start_column;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [2:0] out_line;
    logic [5:0] out_column;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_dec;
    logic is_signed;
    logic cnt_zero;
    logic pos_zero;
    logic conv_last;
    logic slot_free;
  } dp_stat_t;

  function automatic logic [6:0] char_of(input logic [3:0] digit);
    logic [6:0] code;
    if (digit < 4'd10) begin
      code = CHAR_ZERO + {3'b000, digit};
    end else begin
      code = CHAR_A + {3'b000, digit} - 7'd10;
    end
    return code;
  endfunction

endpackage

### sv/fwna_chan_if.sv
// ----------------------------------------------------------------------------
// fwna_chan_if: valid/ready channel
// Carries one item per handshake; payload type is set per instance.
// ----------------------------------------------------------------------------
interface fwna_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/fixed_width_number_to_ascii.sv
// ----------------------------------------------------------------------------
// fixed_width_number_to_ascii: binary value to fixed-width ASCII characters
// Unsigned/signed decimal, uppercase hex and binary; one output item per
// character, most significant digit first, tagged with line and column.
// ----------------------------------------------------------------------------
//   channel  | direction | payload
//   in_ch    | sink      | operation, value, digit_count, text_line, start_column
//   out_ch   | source    | char_code, out_line, out_column, last_char
//
// One item in flight. Hex/binary: set-up in IDLE and DISPATCH, then one
// character per cycle unless the output stalls. Decimal: the same set-up,
// then the BCD pass (one bit per cycle through the BCD shifter), then as above.
// Output stalls hold the output register and pause emission; the next item is
// accepted once the last character has been placed in the output register.
// Reset is synchronous, active low, and clears the controller and out valid.
module fixed_width_number_to_ascii #(
  parameter int MAX_DIGITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  fwna_chan_if.sink        in_ch,
  fwna_chan_if.source      out_ch
);

  fwna_pkg::ctrl_cmd_t cmd;
  fwna_pkg::dp_stat_t  stat;

  fwna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fwna_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

### sv/fwna_ctrl.sv
// ----------------------------------------------------------------------------
// fwna_ctrl: sequencing controller
// Accepts an item, runs the binary to BCD pass for decimal modes, then steps
// the sign and digit emission as the output slot frees up.
// ----------------------------------------------------------------------------
module fwna_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fwna_pkg::dp_stat_t   stat,
  output fwna_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_CONV     = 5'b00100,
    S_SIGN     = 5'b01000,
    S_DIGIT    = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_dec) begin
          state_nxt = S_CONV;
        end else if (stat.cnt_zero) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_last) begin
          if (stat.is_signed) begin
            state_nxt = S_SIGN;
          end else if (stat.cnt_zero) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DIGIT;
          end
        end
      end
      S_SIGN: begin
        if (stat.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = stat.cnt_zero ? S_IDLE : S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (stat.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.pos_zero) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/fwna_dp.sv
// ----------------------------------------------------------------------------
// fwna_dp: conversion datapath
// Holds the item, a shift-add-3 BCD converter (one bit per cycle), the digit
// position and column counters, and the output item register.
// ----------------------------------------------------------------------------
module fwna_dp #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fwna_pkg::in_item_t    in_data,
  input  fwna_pkg::ctrl_cmd_t   cmd,
  output fwna_pkg::dp_stat_t    stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fwna_pkg::out_item_t   out_data
);

  localparam logic [fwna_pkg::COUNT_W-1:0] MAX_CNT = fwna_pkg::COUNT_W'(MAX_DIGITS);

  logic [1:0]                    op_r, op_nxt;
  logic [fwna_pkg::VALUE_W-1:0]  mag_r, mag_nxt;
  logic [fwna_pkg::BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [fwna_pkg::BCD_W-1:0]    bcd_adj;
  logic [fwna_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [fwna_pkg::COUNT_W-1:0]  pos_r, pos_nxt;
  logic [fwna_pkg::COUNT_W-1:0]  cnt_sat;
  logic                          cnt_zero_r, cnt_zero_nxt;
  logic                          plus_r, plus_nxt;
  logic [2:0]                    line_r, line_nxt;
  logic [5:0]                    col_r, col_nxt;
  logic                          out_valid_r, out_valid_nxt;
  fwna_pkg::out_item_t           out_data_r, out_data_nxt;
  logic                          positive;
  logic [3:0]                    digit;

  assign positive = (|in_data.value) && !in_data.value[fwna_pkg::VALUE_W-1];
  assign cnt_sat  = (in_data.digit_count > MAX_CNT) ? MAX_CNT : in_data.digit_count;

  always_comb begin
    for (int i = 0; i < fwna_pkg::DEC_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                   : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    digit = 4'd0;
    case (op_r)
      fwna_pkg::OP_HEX: begin
        if (pos_r < fwna_pkg::COUNT_W'(fwna_pkg::HEX_DIGITS)) begin
          digit = mag_r[{pos_r[2:0], 2'b00} +: 4];
        end
      end
      fwna_pkg::OP_BIN: begin
        digit = {3'b000, mag_r[pos_r[4:0]]};
      end
      default: begin
        if (pos_r < fwna_pkg::COUNT_W'(fwna_pkg::DEC_DIGITS)) begin
          digit = bcd_r[{pos_r[3:0], 2'b00} +: 4];
        end
      end
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    cnt_zero_nxt  = cnt_zero_r;
    plus_nxt      = plus_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      op_nxt       = in_data.operation;
      plus_nxt     = positive;
      mag_nxt      = (in_data.operation == fwna_pkg::OP_SDEC && !positive)
                     ? (fwna_pkg::VALUE_W'(0) - in_data.value) : in_data.value;
      bcd_nxt      = '0;
      step_nxt     = '0;
      pos_nxt      = cnt_sat - fwna_pkg::COUNT_W'(1);
      cnt_zero_nxt = (cnt_sat == '0);
      line_nxt     = in_data.text_line;
      col_nxt      = {1'b0, in_data.start_column};
    end

    if (cmd.conv_step) begin
      bcd_nxt  = {bcd_adj[fwna_pkg::BCD_W-2:0], mag_r[fwna_pkg::VALUE_W-1]};
      mag_nxt  = {mag_r[fwna_pkg::VALUE_W-2:0], 1'b0};
      step_nxt = step_r + fwna_pkg::STEP_W'(1);
    end

    if (cmd.emit_sign) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.char_code  = plus_r ? fwna_pkg::CHAR_PLUS : fwna_pkg::CHAR_MINUS;
      out_data_nxt.out_line   = line_r;
      out_data_nxt.out_column = col_r;
      out_data_nxt.last_char  = cnt_zero_r;
      col_nxt                 = col_r + 6'd1;
    end

    if (cmd.emit_digit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.char_code  = fwna_pkg::char_of(digit);
      out_data_nxt.out_line   = line_r;
      out_data_nxt.out_column = col_r;
      out_data_nxt.last_char  = (pos_r == '0);
      col_nxt                 = col_r + 6'd1;
      pos_nxt                 = pos_r - fwna_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    step_r     <= step_nxt;
    pos_r      <= pos_nxt;
    cnt_zero_r <= cnt_zero_nxt;
    plus_r     <= plus_nxt;
    line_r     <= line_nxt;
    col_r      <= col_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.is_dec    = (op_r == fwna_pkg::OP_UDEC) || (op_r == fwna_pkg::OP_SDEC);
  assign stat.is_signed = (op_r == fwna_pkg::OP_SDEC);
  assign stat.cnt_zero  = cnt_zero_r;
  assign stat.pos_zero  = (pos_r == '0);
  assign stat.conv_last = (step_r == '1);
  assign stat.slot_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/fwna_char_checker.sv
// ----------------------------------------------------------------------------
// fwna_char_checker: character stream checker for fixed_width_number_to_ascii
// Watches both channels. Each accepted number is expanded into the
// characters it should produce, and every accepted character is compared
// field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module fwna_char_checker
  import fwna_pkg::*;
#(
  parameter int MAX_DIGITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        pending
);

  out_item_t owed_chars[$];
  int        fault_cnt = 0;

  function automatic logic [3:0] digit_at_pos(input logic [1:0] op, input logic [31:0] mag,
                                              input int unsigned pos);
    logic [31:0] scale;
    scale = 32'd1;
    case (op)
      OP_HEX: begin
        return (pos >= HEX_DIGITS) ? 4'd0 : 4'(mag >> (4 * pos));
      end
      OP_BIN: begin
        return (pos >= 32) ? 4'd0 : {3'b000, mag[pos]};
      end
      default: begin
        if (pos >= DEC_DIGITS) return 4'd0;
        for (int i = 0; i < pos; i++) scale = scale * 32'd10;
        return 4'((mag / scale) % 32'd10);
      end
    endcase
  endfunction

  function automatic logic [6:0] ascii_of(input logic [3:0] digit);
    return (digit < 4'd10) ? CHAR_ZERO + 7'(digit) : CHAR_A + 7'(digit) - 7'd10;
  endfunction

  function automatic void owe_chars(input in_item_t num);
    out_item_t   c;
    logic [31:0] mag;
    logic        positive;
    int unsigned cnt;
    int unsigned offset;
    int unsigned pos;
    cnt        = (num.digit_count > MAX_DIGITS) ? MAX_DIGITS : num.digit_count;
    mag        = num.value;
    offset     = 0;
    c.out_line = num.text_line;
    if (num.operation == OP_SDEC) begin
      // zero counts as not positive, so it shows a minus
      positive     = (num.value != 32'd0) && !num.value[31];
      mag          = positive ? num.value : 32'd0 - num.value;
      c.char_code  = positive ? CHAR_PLUS : CHAR_MINUS;
      c.out_column = {1'b0, num.start_column};
      c.last_char  = (cnt == 0);
      owed_chars.push_back(c);
      offset = 1;
    end
    for (int i = 0; i < cnt; i++) begin
      pos          = cnt - 1 - i;
      c.char_code  = ascii_of(digit_at_pos(num.operation, mag, pos));
      c.out_column = 6'(num.start_column + offset + i);
      c.last_char  = (pos == 0);
      owed_chars.push_back(c);
    end
  endfunction

  function automatic void note_fault(input string what, input out_item_t got,
                                     input out_item_t want);
    fault_cnt++;
    if (fault_cnt <= 10) begin
      $display("%s: got char %h line %0d col %0d last %0b,",
               what, got.char_code, got.out_line, got.out_column, got.last_char,
               " expected char %h line %0d col %0d last %0b",
               want.char_code, want.out_line, want.out_column, want.last_char);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) owe_chars(in_data);
      if (out_valid && out_ready) begin
        if (owed_chars.size() == 0) begin
          note_fault("unexpected item", out_data, '0);
        end else begin
          want = owed_chars.pop_front();
          if (out_data.char_code != want.char_code || out_data.out_line != want.out_line ||
              out_data.out_column != want.out_column || out_data.last_char != want.last_char) begin
            note_fault("mismatch", out_data, want);
          end
        end
      end
    end
    mismatches <= fault_cnt;
    pending    <= owed_chars.size();
  end

endmodule

### tb/fixed_width_number_to_ascii_tb.sv
// ----------------------------------------------------------------------------
// fixed_width_number_to_ascii_tb: testbench for fixed_width_number_to_ascii
// Sends directed numbers covering every mode, the sign rule, zero and long
// digit counts and wide positions, then random numbers with random gaps and
// output stalls, including one long output hold-off. Checking is done by
// fwna_char_checker.
// ----------------------------------------------------------------------------
module fixed_width_number_to_ascii_tb;
  import fwna_pkg::*;

  localparam int MAX_DIGITS  = 32;
  localparam int RANDOM_NUMS = 80;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic hold_req;
  int   mismatches;
  int   pending;
  int   cycles = 0;

  int unsigned hold_left;
  int unsigned free_left;
  logic        long_hold_done;
  int unsigned pick;

  fwna_chan_if #(.T(in_item_t))  in_ch ();
  fwna_chan_if #(.T(out_item_t)) out_ch ();

  fixed_width_number_to_ascii #(
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  fwna_char_checker #(
    .MAX_DIGITS(MAX_DIGITS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("fixed_width_number_to_ascii_tb: done, errors");
      $finish;
    end
  end

  // receiver: random ready, short stalls, free-running stretches, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready   <= 1'b0;
      hold_left      <= 0;
      free_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !long_hold_done) begin
      out_ch.ready   <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (free_left != 0) begin
      out_ch.ready <= 1'b1;
      free_left    <= free_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        out_ch.ready <= 1'b0;
        hold_left    <= $urandom_range(15, 80);
      end else if (pick < 10) begin
        out_ch.ready <= 1'b1;
        free_left    <= $urandom_range(20, 100);
      end else begin
        out_ch.ready <= (pick >= 35);
      end
    end
  end

  function automatic in_item_t number_item(input logic [1:0] op, input logic [31:0] value,
                                           input int cnt, input int line, input int col);
    in_item_t num;
    num.operation    = op;
    num.value        = value;
    num.digit_count  = 6'(cnt);
    num.text_line    = 3'(line);
    num.start_column = 5'(col);
    return num;
  endfunction

  function automatic in_item_t random_number();
    in_item_t    num;
    int unsigned r;
    num.operation = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 9);
    case (r)
      0:       num.value = 32'd0;
      1:       num.value = 32'hFFFF_FFFF;
      2:       num.value = 32'h8000_0000;
      3:       num.value = 32'h7FFF_FFFF;
      4, 5:    num.value = $urandom_range(0, 999);
      6:       num.value = 32'd0 - $urandom_range(1, 999);
      default: num.value = $urandom;
    endcase
    r = $urandom_range(0, 9);
    if (r < 7) num.digit_count = 6'($urandom_range(0, 12));
    else if (r < 9) num.digit_count = 6'($urandom_range(13, 32));
    else num.digit_count = 6'($urandom_range(33, 63));
    num.text_line    = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(1, 4))
                                                   : 3'($urandom_range(0, 7));
    num.start_column = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(1, 16))
                                                   : 5'($urandom_range(0, 31));
    return num;
  endfunction

  function automatic int sender_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // entered and left at a rising edge; valid stays high when the next item follows at once
  task automatic send_number(input in_item_t num);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= num;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t directed[$];
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    hold_req    <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(number_item(OP_UDEC, 32'd0, 10, 1, 1));
    directed.push_back(number_item(OP_UDEC, 32'hFFFF_FFFF, 10, 2, 5));
    directed.push_back(number_item(OP_UDEC, 32'd12345, 32, 3, 16));
    directed.push_back(number_item(OP_UDEC, 32'd1, 0, 4, 2));
    directed.push_back(number_item(OP_UDEC, 32'hFFFF_FFFF, 40, 1, 3));
    directed.push_back(number_item(OP_SDEC, 32'd0, 3, 1, 1));
    directed.push_back(number_item(OP_SDEC, 32'd1, 1, 2, 2));
    directed.push_back(number_item(OP_SDEC, 32'h7FFF_FFFF, 10, 3, 4));
    directed.push_back(number_item(OP_SDEC, 32'h8000_0000, 10, 4, 6));
    directed.push_back(number_item(OP_SDEC, 32'hFFFF_FFFF, 10, 1, 7));
    directed.push_back(number_item(OP_SDEC, 32'd5, 0, 2, 8));
    directed.push_back(number_item(OP_SDEC, 32'h0000_FFFF, 5, 3, 9));
    directed.push_back(number_item(OP_SDEC, 32'h8000_0000, 32, 4, 31));
    directed.push_back(number_item(OP_HEX, 32'hDEAD_BEEF, 8, 1, 10));
    directed.push_back(number_item(OP_HEX, 32'hFFFF_FFFF, 12, 2, 11));
    directed.push_back(number_item(OP_HEX, 32'd0, 0, 3, 12));
    directed.push_back(number_item(OP_HEX, 32'h0123_ABCD, 33, 0, 0));
    directed.push_back(number_item(OP_BIN, 32'hA5A5_A5A5, 32, 4, 13));
    directed.push_back(number_item(OP_BIN, 32'hFFFF_FFFF, 63, 7, 31));
    directed.push_back(number_item(OP_BIN, 32'd0, 0, 5, 14));
    directed.push_back(number_item(OP_BIN, 32'h5A5A_5A5A, 3, 6, 15));
    foreach (directed[i]) send_number(directed[i]);
    drain_results();

    for (int i = 0; i < RANDOM_NUMS; i++) begin
      if (i == 30) hold_req <= 1'b1;
      if (i == 60) drain_results();
      send_number(random_number());
    end
    drain_results();
    repeat (100) @(posedge clk);

    if (mismatches == 0) begin
      $display("fixed_width_number_to_ascii_tb: done, clean");
    end else begin
      $display("fixed_width_number_to_ascii_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/fwna_pkg.sv
sv/fwna_chan_if.sv
sv/fwna_ctrl.sv
sv/fwna_dp.sv
sv/fixed_width_number_to_ascii.sv
tb/fwna_char_checker.sv
tb/fixed_width_number_to_ascii_tb.sv
